### rtl/dfscc_pkg.sv
// ---------------------------------------------------------------------------
// dfscc_pkg: shared codes and control types
// Status codes, controller commands and datapath status for the DFS block.
// ---------------------------------------------------------------------------
`default_nettype none
package dfscc_pkg;

  localparam int VTX_W = 6;
  localparam int CNT_W = 7;
  localparam int STAT_W = 2;
  localparam int FIELD_VMAX = 64;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic load;        // latch the incoming word
    logic run_init;    // clear visited map, counters and stack
    logic head_rd_a;   // read list head of endpoint a
    logic head_rd_b;   // read list head of endpoint b
    logic wr_a;        // push node holding b onto list a
    logic wr_b;        // push node holding a onto list b
    logic emit_ack;    // drive insert acknowledgement
    logic scan_inc;    // advance scan index
    logic scan_start;  // start a component at the scan index
    logic visit_emit;  // emit visit, mark visited, save cursor, read head
    logic push;        // take head as new top cursor
    logic comp_next;   // close component, advance scan
    logic pop;         // drop top entry
    logic pop_take;    // load cursor of new top
    logic node_rd;     // read node at top cursor
    logic node_take;   // advance cursor, select neighbor
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic ins_reject;
    logic scan_visited;
    logic depth_zero;
    logic cur_null;
    logic w_new;
    logic is_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### rtl/dfscc_ctrl.sv
// ---------------------------------------------------------------------------
// dfscc_ctrl: sequencer
// State machine that steps the datapath through inserts and the DFS walk.
// ---------------------------------------------------------------------------
`default_nettype none
module dfscc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire dfscc_pkg::sts_t sts,
  output dfscc_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INSRA = 4'd1;
  localparam logic [3:0] S_INSWA = 4'd2;
  localparam logic [3:0] S_INSRB = 4'd3;
  localparam logic [3:0] S_INSWB = 4'd4;
  localparam logic [3:0] S_ACK   = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_VISIT = 4'd7;
  localparam logic [3:0] S_PUSH  = 4'd8;
  localparam logic [3:0] S_WALK  = 4'd9;
  localparam logic [3:0] S_NODEW = 4'd10;
  localparam logic [3:0] S_POPW  = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.mode) begin
            cmd.run_init = 1'b1;
            state_nxt = S_SCAN;
          end else if (sts.ins_reject) begin
            state_nxt = S_ACK;
          end else begin
            state_nxt = S_INSRA;
          end
        end
      end
      S_INSRA: begin
        cmd.head_rd_a = 1'b1;
        state_nxt = S_INSWA;
      end
      S_INSWA: begin
        cmd.wr_a = 1'b1;
        state_nxt = S_INSRB;
      end
      S_INSRB: begin
        cmd.head_rd_b = 1'b1;
        state_nxt = S_INSWB;
      end
      S_INSWB: begin
        cmd.wr_b = 1'b1;
        state_nxt = S_ACK;
      end
      S_ACK: begin
        if (sts.out_free) begin
          cmd.emit_ack = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.scan_visited) begin
          cmd.scan_inc = 1'b1;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt = S_VISIT;
        end
      end
      S_VISIT: begin
        if (sts.out_free) begin
          cmd.visit_emit = 1'b1;
          state_nxt = sts.is_last ? S_IDLE : S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.depth_zero) begin
          cmd.comp_next = 1'b1;
          state_nxt = S_SCAN;
        end else if (sts.cur_null) begin
          cmd.pop = 1'b1;
          state_nxt = S_POPW;
        end else begin
          cmd.node_rd = 1'b1;
          state_nxt = S_NODEW;
        end
      end
      S_NODEW: begin
        cmd.node_take = 1'b1;
        state_nxt = sts.w_new ? S_VISIT : S_WALK;
      end
      S_POPW: begin
        cmd.pop_take = 1'b1;
        state_nxt = S_WALK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/dfscc_dp.sv
// ---------------------------------------------------------------------------
// dfscc_dp: datapath
// Adjacency store, visited map, cursor stack and output register.
// ---------------------------------------------------------------------------
`default_nettype none
module dfscc_dp #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 128
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [dfscc_pkg::CNT_W-1:0]         cfg_wr_data,
  input  wire logic                                in_mode,
  input  wire logic [dfscc_pkg::VTX_W-1:0]         in_vertex_a,
  input  wire logic [dfscc_pkg::VTX_W-1:0]         in_vertex_b,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [dfscc_pkg::STAT_W-1:0]             out_status,
  output logic                                     out_is_visit,
  output logic [dfscc_pkg::VTX_W-1:0]              out_vertex,
  output logic [dfscc_pkg::VTX_W-1:0]              out_component,
  output logic                                     out_new_component,
  output logic                                     out_last,
  input  wire dfscc_pkg::cmd_t                     cmd,
  output dfscc_pkg::sts_t                          sts
);

  localparam int VW = dfscc_pkg::VTX_W;
  localparam int CW = dfscc_pkg::CNT_W;
  localparam int VLIMIT = (MAX_VERTICES < dfscc_pkg::FIELD_VMAX) ?
                          MAX_VERTICES : dfscc_pkg::FIELD_VMAX;
  localparam int HAW = $clog2(VLIMIT);
  localparam int NODE_CAP = 2 * MAX_EDGES;
  localparam int NW = $clog2(NODE_CAP + 1);
  localparam int AW = $clog2(NODE_CAP);
  localparam logic [NW-1:0] NODE_NULL = NW'(NODE_CAP);
  localparam logic [CW-1:0] VLIM_C = CW'(VLIMIT);

  // configuration and active count
  logic [CW-1:0] vcount_r;
  logic [CW-1:0] n_act;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= CW'(64);
    end else if (cfg_wr_en) begin
      vcount_r <= cfg_wr_data;
    end
  end
  always_comb begin
    if (vcount_r == '0) n_act = CW'(1);
    else if (vcount_r > VLIM_C) n_act = VLIM_C;
    else n_act = vcount_r;
  end

  // latched input word
  logic [VW-1:0] a_r, b_r;
  logic [dfscc_pkg::STAT_W-1:0] ack_st_r, ack_st;
  logic [NW-1:0] used_r;
  logic range_bad, full;

  assign range_bad = ({1'b0, in_vertex_a} >= n_act) || ({1'b0, in_vertex_b} >= n_act);
  assign full = ({1'b0, used_r} + (NW+1)'(2)) > (NW+1)'(NODE_CAP);
  always_comb begin
    if (range_bad) ack_st = dfscc_pkg::ST_RANGE;
    else if (full) ack_st = dfscc_pkg::ST_FULL;
    else ack_st = dfscc_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= in_vertex_a;
      b_r <= in_vertex_b;
      ack_st_r <= ack_st;
    end
  end

  // list heads: memory plus valid bits
  logic [NW-1:0] head_mem [VLIMIT];
  logic [VLIMIT-1:0] head_v_r;
  logic [NW-1:0] head_rd_r;
  logic head_rv_r;
  logic [NW-1:0] head_val;
  logic [VW-1:0] v_r;
  logic [VW-1:0] h_raddr, h_waddr;
  logic h_rd, h_wr;

  assign h_rd = cmd.head_rd_a || cmd.head_rd_b || cmd.visit_emit;
  assign h_raddr = cmd.head_rd_a ? a_r : (cmd.head_rd_b ? b_r : v_r);
  assign h_wr = cmd.wr_a || cmd.wr_b;
  assign h_waddr = cmd.wr_a ? a_r : b_r;
  assign head_val = head_rv_r ? head_rd_r : NODE_NULL;

  always_ff @(posedge clk) begin
    if (h_wr) head_mem[h_waddr[HAW-1:0]] <= used_r;
    if (h_rd) begin
      head_rd_r <= head_mem[h_raddr[HAW-1:0]];
      head_rv_r <= head_v_r[h_raddr[HAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= '0;
      used_r <= '0;
    end else if (h_wr) begin
      head_v_r[h_waddr[HAW-1:0]] <= 1'b1;
      used_r <= used_r + NW'(1);
    end
  end

  // node store
  logic [VW-1:0] nv_mem [NODE_CAP];
  logic [NW-1:0] nn_mem [NODE_CAP];
  logic [VW-1:0] nv_rd_r;
  logic [NW-1:0] nn_rd_r;
  logic [NW-1:0] cur_r;

  always_ff @(posedge clk) begin
    if (h_wr) begin
      nv_mem[used_r[AW-1:0]] <= cmd.wr_a ? b_r : a_r;
      nn_mem[used_r[AW-1:0]] <= head_val;
    end
    if (cmd.node_rd) begin
      nv_rd_r <= nv_mem[cur_r[AW-1:0]];
      nn_rd_r <= nn_mem[cur_r[AW-1:0]];
    end
  end

  // walk state
  logic [VLIMIT-1:0] visited_r;
  logic [CW-1:0] depth_r, i_r, comp_r, vcnt_r;
  logic start_r;
  logic [NW-1:0] stk_mem [VLIMIT];
  logic [NW-1:0] stk_rd_r;
  logic [CW-1:0] depth_m1, depth_m2;

  assign depth_m1 = depth_r - CW'(1);
  assign depth_m2 = depth_r - CW'(2);

  always_ff @(posedge clk) begin
    if (cmd.visit_emit && depth_r != '0) stk_mem[depth_m1[HAW-1:0]] <= cur_r;
    if (cmd.pop) stk_rd_r <= stk_mem[depth_m2[HAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      depth_r <= '0;
      i_r <= '0;
      comp_r <= '0;
      vcnt_r <= '0;
      start_r <= 1'b0;
    end else begin
      if (cmd.run_init) begin
        visited_r <= '0;
        depth_r <= '0;
        i_r <= '0;
        comp_r <= '0;
        vcnt_r <= '0;
      end
      if (cmd.scan_inc) i_r <= i_r + CW'(1);
      if (cmd.scan_start) begin
        v_r <= i_r[VW-1:0];
        start_r <= 1'b1;
      end
      if (cmd.visit_emit) begin
        visited_r[v_r[HAW-1:0]] <= 1'b1;
        vcnt_r <= vcnt_r + CW'(1);
      end
      if (cmd.push) begin
        cur_r <= head_val;
        depth_r <= depth_r + CW'(1);
      end
      if (cmd.comp_next) begin
        comp_r <= comp_r + CW'(1);
        i_r <= i_r + CW'(1);
      end
      if (cmd.pop) depth_r <= depth_m1;
      if (cmd.pop_take && depth_r != '0) cur_r <= stk_rd_r;
      if (cmd.node_take) begin
        cur_r <= nn_rd_r;
        v_r <= nv_rd_r;
        start_r <= 1'b0;
      end
    end
  end

  // output register
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_ack || cmd.visit_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ack) begin
      out_status <= ack_st_r;
      out_is_visit <= 1'b0;
      out_vertex <= '0;
      out_component <= '0;
      out_new_component <= 1'b0;
      out_last <= 1'b1;
    end else if (cmd.visit_emit) begin
      out_status <= dfscc_pkg::ST_OK;
      out_is_visit <= 1'b1;
      out_vertex <= v_r;
      out_component <= comp_r[VW-1:0];
      out_new_component <= start_r;
      out_last <= sts.is_last;
    end
  end

  assign sts.mode = in_mode;
  assign sts.ins_reject = range_bad || full;
  assign sts.scan_visited = visited_r[i_r[HAW-1:0]];
  assign sts.depth_zero = (depth_r == '0);
  assign sts.cur_null = (cur_r >= NODE_NULL);
  assign sts.w_new = ({1'b0, nv_rd_r} < n_act) && !visited_r[nv_rd_r[HAW-1:0]];
  assign sts.is_last = ((vcnt_r + CW'(1)) == n_act);
  assign sts.out_free = out_free;

endmodule
`default_nettype wire

### rtl/dfs_connected_components.sv
// ---------------------------------------------------------------------------
// dfs_connected_components: connected components by depth-first search
// Edge loader into adjacency lists and a stack-based DFS that reports
// every vertex in visit order with its component number.
// ---------------------------------------------------------------------------
// One word at a time. An accepted insert (mode 0) runs two list head reads
// and two node writes, then one acknowledgement; a rejected insert goes
// straight to it. A run (mode 1) emits one result per active vertex
// (vertex_count, 0 as one, clamped to the limit): the scan steps past
// visited vertices, each component is started and closed, each adjacency
// node walked is read and taken, and each visit is emitted, pushed and later
// popped with its cursor stack read. The run ends at the last visit, which
// carries the last flag. Output stall holds the walk at the next visit. The
// visited map and list head valid bits reset at once; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none
module dfs_connected_components #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 128
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [6:0]                  cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_mode,
  input  wire logic [5:0]                  in_vertex_a,
  input  wire logic [5:0]                  in_vertex_b,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic                             out_is_visit,
  output logic [5:0]                       out_vertex,
  output logic [5:0]                       out_component,
  output logic                             out_new_component,
  output logic                             out_last
);

  // command and status between sequencer and datapath
  dfscc_pkg::cmd_t cmd;
  dfscc_pkg::sts_t sts;

  dfscc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dfscc_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_mode           (in_mode),
    .in_vertex_a       (in_vertex_a),
    .in_vertex_b       (in_vertex_b),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_is_visit      (out_is_visit),
    .out_vertex        (out_vertex),
    .out_component     (out_component),
    .out_new_component (out_new_component),
    .out_last          (out_last),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
`default_nettype wire

### rtl/dfscc_checker.sv
// ---------------------------------------------------------------------------
// dfscc_props: port-level checks
// Watches the top level ports and flags inconsistent result words.
// ---------------------------------------------------------------------------
`default_nettype none
module dfscc_props (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_status,
  input wire logic       out_is_visit,
  input wire logic [5:0] out_vertex,
  input wire logic       out_last
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vertex) && $stable(out_last))
    else $error("stalled result word changed");

  // an accepted word always starts work, so the input side stalls next
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  // insert acknowledgements are single, final and zero-filled
  a_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_visit |-> out_last && out_vertex == 6'd0)
    else $error("malformed insert acknowledgement");

  // visits always report ok
  a_visit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_visit |-> out_status == 2'd0)
    else $error("visit with nonzero status");

endmodule

bind dfs_connected_components dfscc_props u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_status   (out_status),
  .out_is_visit (out_is_visit),
  .out_vertex   (out_vertex),
  .out_last     (out_last)
);
`default_nettype wire

### tb/dfscc_checker.sv
// ---------------------------------------------------------------------------
// dfscc_checker: visit-order predictor and result checker
// Watches the word, configuration and result channels of the DFS block,
// predicts every result from its own copy of the graph and compares.
// ---------------------------------------------------------------------------
module dfscc_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_mode,
  input  logic [5:0] in_vertex_a,
  input  logic [5:0] in_vertex_b,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_status,
  input  logic       out_is_visit,
  input  logic [5:0] out_vertex,
  input  logic [5:0] out_component,
  input  logic       out_new_component,
  input  logic       out_last,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES    = 256;
  localparam int NODE_NIL = NODES;

  typedef struct packed {
    logic [1:0] status;
    logic       is_visit;
    logic [5:0] vertex;
    logic [5:0] component;
    logic       new_comp;
    logic       last;
  } result_word_t;

  result_word_t expected_words[$];

  logic [8:0] head_of[64];
  logic [5:0] node_vtx[NODES];
  logic [8:0] node_link[NODES];
  int         node_fill;
  logic       seen[64];
  logic [5:0] stk_vtx[64];
  logic [8:0] stk_cur[64];
  int         stk_depth;
  int         comp_no;
  logic [6:0] vcount;

  function automatic int live_count();
    if (vcount == 0) return 1;
    if (vcount > 64) return 64;
    return vcount;
  endfunction

  function automatic void add_node(int owner, logic [5:0] value);
    node_vtx[node_fill]  = value;
    node_link[node_fill] = head_of[owner];
    head_of[owner]       = node_fill[8:0];
    node_fill++;
  endfunction

  function automatic void mark_visit(int v, logic starts);
    result_word_t r;
    seen[v] = 1'b1;
    r = '{dfscc_pkg::ST_OK, 1'b1, v[5:0], comp_no[5:0], starts, 1'b0};
    expected_words.push_back(r);
    if (stk_depth < 64) begin
      stk_vtx[stk_depth] = v[5:0];
      stk_cur[stk_depth] = head_of[v];
      stk_depth++;
    end
  endfunction

  // Insert: one ack; run: one visit word per live vertex, last on the final one.
  function automatic void predict_word(logic mode, logic [5:0] a, logic [5:0] b);
    int n;
    int top;
    int cur;
    int w;
    result_word_t r;
    n = live_count();
    if (!mode) begin
      r = '{dfscc_pkg::ST_OK, 1'b0, 6'd0, 6'd0, 1'b0, 1'b1};
      if (a >= n || b >= n) r.status = dfscc_pkg::ST_RANGE;
      else if (node_fill + 2 > NODES) r.status = dfscc_pkg::ST_FULL;
      else begin
        add_node(a, b);
        add_node(b, a);
      end
      expected_words.push_back(r);
      return;
    end
    for (int i = 0; i < 64; i++) seen[i] = 1'b0;
    comp_no = 0;
    stk_depth = 0;
    for (int i = 0; i < n; i++) begin
      if (seen[i]) continue;
      mark_visit(i, 1'b1);
      while (stk_depth > 0) begin
        top = stk_depth - 1;
        cur = stk_cur[top];
        if (cur >= NODES) begin
          stk_depth--;
          continue;
        end
        w = node_vtx[cur];
        stk_cur[top] = node_link[cur];
        if (w < n && !seen[w]) mark_visit(w, 1'b0);
      end
      comp_no = (comp_no + 1) & 127;
    end
    expected_words[expected_words.size()-1].last = 1'b1;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    result_word_t e;
    if (!rst_n) begin
      for (int i = 0; i < 64; i++) begin
        head_of[i] = 9'(NODE_NIL);
        seen[i] = 1'b0;
      end
      node_fill = 0;
      stk_depth = 0;
      comp_no = 0;
      vcount = 7'd64;
      expected_words.delete();
    end else begin
      if (cfg_wr_en) vcount = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report("unexpected result word count", 1, 0);
        end else begin
          e = expected_words.pop_front();
          if (out_status != e.status) report("status", out_status, e.status);
          if (out_is_visit != e.is_visit) report("is_visit", out_is_visit, e.is_visit);
          if (out_vertex != e.vertex) report("vertex", out_vertex, e.vertex);
          if (out_component != e.component)
            report("component", out_component, e.component);
          if (out_new_component != e.new_comp)
            report("new_component", out_new_component, e.new_comp);
          if (out_last != e.last) report("last", out_last, e.last);
        end
      end
      if (in_valid && !in_stall) predict_word(in_mode, in_vertex_a, in_vertex_b);
    end
    pending = expected_words.size();
  end

endmodule

### tb/tb_dfs_connected_components.sv
// ---------------------------------------------------------------------------
// tb_dfs_connected_components: testbench top for the DFS component search
// Drives edge inserts and runs in bursts under random output stall, moves
// vertex_count through its extremes between phases and reports the verdict.
// ---------------------------------------------------------------------------
module tb_dfs_connected_components;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_mode = 1'b0;
  logic [5:0] in_vertex_a = '0;
  logic [5:0] in_vertex_b = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  logic       out_is_visit;
  logic [5:0] out_vertex;
  logic [5:0] out_component;
  logic       out_new_component;
  logic       out_last;
  int         fail_count;
  int         pending;

  // Sender burst bookkeeping and the register value last written.
  int         burst_left = 0;
  logic [6:0] count_now = 7'd64;

  dfs_connected_components i_dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_valid, .in_stall, .in_mode, .in_vertex_a, .in_vertex_b,
    .out_valid, .out_stall, .out_status, .out_is_visit, .out_vertex,
    .out_component, .out_new_component, .out_last
  );

  dfscc_checker i_checker (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_valid, .in_stall, .in_mode, .in_vertex_a, .in_vertex_b,
    .out_valid, .out_stall, .out_status, .out_is_visit, .out_vertex,
    .out_component, .out_new_component, .out_last,
    .fail_count, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stall: switch at random intervals between free flow, light
  // random stall, periodic stall bursts and heavy random stall.
  int stall_style = 0;
  int stall_timer = 0;
  always @(negedge clk) begin
    if (stall_timer == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_timer = $urandom_range(20, 120);
    end
    stall_timer--;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ((stall_timer % 16) < 6);
      default: out_stall <= ($urandom_range(0, 99) < 70);
    endcase
  end

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  function automatic int live_limit();
    if (count_now == 0) return 1;
    if (count_now > 64) return 64;
    return count_now;
  endfunction

  // Send one word; called and returns at a falling edge. Insert a gap
  // between bursts, then hold the word until it is taken. Stall is
  // looked at on falling edges, where it is settled for the next rise.
  task automatic send_word(logic mode, logic [5:0] a, logic [5:0] b);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid    = 1'b1;
    in_mode     = mode;
    in_vertex_a = a;
    in_vertex_b = b;
    while (in_stall) @(negedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Let every expected word drain, then let the block settle.
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Write vertex_count only while the block is idle.
  task automatic set_count(logic [6:0] value);
    drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    count_now   = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    int n;
    logic [6:0] picks[8];
    picks = '{7'd1, 7'd64, 7'd2, 7'd16, 7'd40, 7'd127, 7'd0, 7'd65};
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: extreme endpoints, self loop, runs on the reset count.
    send_word(1'b0, 6'd0, 6'd63);
    send_word(1'b0, 6'd63, 6'd0);
    send_word(1'b0, 6'd5, 6'd5);
    send_word(1'b0, 6'd62, 6'd1);
    send_word(1'b1, 6'd63, 6'd63);
    // Shrink the count: range rejects, leftover high neighbors skipped.
    set_count(7'd4);
    send_word(1'b0, 6'd4, 6'd1);
    send_word(1'b0, 6'd1, 6'd9);
    send_word(1'b0, 6'd63, 6'd63);
    send_word(1'b0, 6'd0, 6'd3);
    send_word(1'b0, 6'd3, 6'd2);
    send_word(1'b1, 6'd0, 6'd0);
    // Count 0 behaves as one vertex.
    set_count(7'd0);
    send_word(1'b0, 6'd0, 6'd0);
    send_word(1'b0, 6'd0, 6'd1);
    send_word(1'b1, 6'd21, 6'd42);
    // Above the limit clamps to 64.
    set_count(7'd127);
    send_word(1'b0, 6'd42, 6'd21);
    send_word(1'b1, 6'd0, 6'd0);

    // Random phases: mostly in-range inserts, which fill the edge store,
    // with runs, stray endpoints and a register change between phases.
    for (int phase = 0; phase < 6; phase++) begin
      set_count(phase == 0 ? 7'd64 : picks[$urandom_range(0, 7)]);
      n = live_limit();
      for (int k = 0; k < 42; k++) begin
        int pick;
        pick = $urandom_range(0, 99);
        if (phase == 2 && k == 20) drain();
        if (pick < 72)
          send_word(1'b0, 6'($urandom_range(0, n - 1)), 6'($urandom_range(0, n - 1)));
        else if (pick < 82)
          send_word(1'b0, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        else
          send_word(1'b1, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      end
    end

    drain();
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/dfscc_pkg.sv
rtl/dfscc_ctrl.sv
rtl/dfscc_dp.sv
rtl/dfs_connected_components.sv
rtl/dfscc_checker.sv
tb/dfscc_checker.sv
tb/tb_dfs_connected_components.sv
